// ===== hdl/scp_pkg.sv =====
// Shared types, constants and helper functions for the slotted command packet parser.
`timescale 1ns / 1ps

package scp_pkg;

    localparam int PACKET_BYTES   = 55;
    localparam int SLOT_COUNT     = 6;
    localparam int SLOT_BYTES     = 9;
    localparam int INDEX_MAX      = 63;
    localparam int ACCEL_MAX      = 40;
    localparam int DELAY_PER_SLOT = 3000;
    localparam int DELAY_MIN      = 2;

    localparam int IDX_W   = 6;
    localparam int SLOT_W  = 3;
    localparam int OFF_W   = 4;
    localparam int DELAY_W = 14;

    localparam int OFF_HIGH  = 3;
    localparam int OFF_ID    = 4;
    localparam int OFF_KICK  = 5;
    localparam int OFF_FLAGS = 6;
    localparam int OFF_ACCEL = 7;

    typedef enum logic [1:0] {
        ST_MATCH   = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_BADLEN  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]        seq;
        logic [SLOT_W-1:0] slot;
        logic [9:0]        vel_x;
        logic [9:0]        vel_y;
        logic [9:0]        vel_w;
        logic [8:0]        drib;
        logic [7:0]        kick;
        logic [3:0]        flags;
        logic [5:0]        accel;
    } pend_t;

    typedef struct packed {
        status_t            status;
        logic [2:0]         seq;
        logic [SLOT_W-1:0]  slot;
        logic [9:0]         vel_x;
        logic [9:0]         vel_y;
        logic [9:0]         vel_w;
        logic [8:0]         drib;
        logic [7:0]         kick;
        logic [3:0]         flags;
        logic [5:0]         accel;
        logic [DELAY_W-1:0] delay;
    } res_t;

    function automatic logic [DELAY_W-1:0] reply_delay(input logic [SLOT_W-1:0] slot);
        logic [DELAY_W+SLOT_W-1:0] prod;
        begin
            prod = (DELAY_W+SLOT_W)'(slot) * (DELAY_W+SLOT_W)'(DELAY_PER_SLOT);
            if (prod < (DELAY_W+SLOT_W)'(DELAY_MIN))
            begin
                prod = (DELAY_W+SLOT_W)'(DELAY_MIN);
            end
            return prod[DELAY_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/slotted_command_packet_parser.sv =====
// Top level of the slotted command packet parser.
//
// Received packet bytes arrive as requests on the slave stream, one byte per
// request, with s_tlast set on the final byte of a packet. Each packet yields
// exactly one result request on the master stream, issued on the last byte.
// A byte is taken every cycle while s_tready is high; throughput is one byte
// per cycle, set by the single capture stage that handles each byte as it is
// accepted. The result is registered in the output register behind m_tvalid,
// or in the skid register while it stalls. The receive id is written through
// own_id_wr_en and own_id_wr_data; the user must write it only while the block
// is idle, which the block does not enforce. A skid register backs the output
// register; a stalled receiver holds one result while one more is captured, and
// s_tready drops only when both are full. Reset clears the byte position, kept
// kick values, receive id and both output stages; the next byte opens a packet.
`timescale 1ns / 1ps

module slotted_command_packet_parser
    import scp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        own_id_wr_en,
    input  logic [3:0]  own_id_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // rx_byte
    input  logic        s_tlast,  // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // seq_number, matched_slot, vel_x, vel_y, vel_w, dribbler_speed,
    // kick_strength, kick_flags, accel_cap, reply_delay, zero fill
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser   // packet_status
);

    logic accept;
    logic res_valid;
    res_t res;
    res_t out_data;

    assign accept = s_tvalid && s_tready;

    scp_capture u_capture (
        .clk            (clk),
        .rst_n          (rst_n),
        .own_id_wr_en   (own_id_wr_en),
        .own_id_wr_data (own_id_wr_data),
        .accept         (accept),
        .rx_byte        (s_tdata),
        .last_byte      (s_tlast),
        .res_valid      (res_valid),
        .res            (res)
    );

    scp_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tuser = out_data.status;
    assign m_tdata = {3'b000, out_data.delay, out_data.accel, out_data.flags, out_data.kick,
                      out_data.drib, out_data.vel_w, out_data.vel_y, out_data.vel_x,
                      out_data.slot, out_data.seq};

endmodule

// ===== hdl/scp_capture.sv =====
// Byte position tracking, slot selection and field capture for each received packet.
`timescale 1ns / 1ps

module scp_capture
    import scp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       own_id_wr_en,
    input  logic [3:0] own_id_wr_data,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       last_byte,
    output logic       res_valid,
    output res_t       res
);

    logic [3:0]        own_id_reg;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic              found_reg, found_next;
    pend_t             pend_reg, pend_next;
    logic [7:0]        kick_reg, kick_next;
    logic [3:0]        flags_reg, flags_next;
    logic [5:0]        accel_reg, accel_next;
    logic [7:0]        sb_reg [4];
    logic              sb_we;
    logic [7:0]        high_bits;
    logic [3:0]        drib_nib;
    logic              in_slot;

    always_comb
    begin
        index_next = index_reg;
        slot_next  = slot_reg;
        off_next   = off_reg;
        found_next = found_reg;
        pend_next  = pend_reg;
        kick_next  = kick_reg;
        flags_next = flags_reg;
        accel_next = accel_reg;
        sb_we      = 1'b0;
        high_bits  = sb_reg[OFF_HIGH];
        drib_nib   = rx_byte[7:4];
        in_slot    = (index_reg < IDX_W'(PACKET_BYTES)) && (slot_reg < SLOT_W'(SLOT_COUNT));
        res_valid  = 1'b0;
        res        = '0;

        if (accept)
        begin
            if (index_reg == '0)
            begin
                pend_next     = '0;
                pend_next.seq = rx_byte[2:0];
                found_next    = 1'b0;
            end
            else if (in_slot)
            begin
                if (off_reg < OFF_W'(OFF_ID))
                begin
                    sb_we = !found_reg;
                end
                else if (off_reg == OFF_W'(OFF_ID))
                begin
                    if (!found_reg && rx_byte[3:0] == own_id_reg)
                    begin
                        found_next      = 1'b1;
                        pend_next.slot  = slot_reg;
                        pend_next.vel_x = {high_bits[1:0], sb_reg[0]};
                        pend_next.vel_y = {high_bits[3:2], sb_reg[1]};
                        pend_next.vel_w = {high_bits[5:4], sb_reg[2]};
                        pend_next.drib  = {drib_nib, drib_nib, drib_nib[3]};
                    end
                end
                else if (found_reg && pend_reg.slot == slot_reg)
                begin
                    if (off_reg == OFF_W'(OFF_KICK))
                    begin
                        pend_next.kick = rx_byte;
                    end
                    else if (off_reg == OFF_W'(OFF_FLAGS))
                    begin
                        pend_next.flags = rx_byte[3:0];
                    end
                    else if (off_reg == OFF_W'(OFF_ACCEL))
                    begin
                        pend_next.accel = (rx_byte > 8'(ACCEL_MAX)) ? 6'(ACCEL_MAX)
                                                                     : rx_byte[5:0];
                    end
                end
            end

            if (index_reg != '0 && index_reg < IDX_W'(PACKET_BYTES))
            begin
                if (off_reg == OFF_W'(SLOT_BYTES - 1))
                begin
                    off_next  = '0;
                    slot_next = slot_reg + 1'b1;
                end
                else
                begin
                    off_next = off_reg + 1'b1;
                end
            end

            if (index_reg != IDX_W'(INDEX_MAX))
            begin
                index_next = index_reg + 1'b1;
            end

            if (last_byte)
            begin
                res_valid = 1'b1;
                if (index_reg != IDX_W'(PACKET_BYTES - 1))
                begin
                    res.status = ST_BADLEN;
                end
                else
                begin
                    res.seq = pend_next.seq;
                    if (found_next)
                    begin
                        kick_next  = pend_next.kick;
                        flags_next = pend_next.flags;
                        accel_next = pend_next.accel;
                        res.status = ST_MATCH;
                        res.slot   = pend_next.slot;
                        res.vel_x  = pend_next.vel_x;
                        res.vel_y  = pend_next.vel_y;
                        res.vel_w  = pend_next.vel_w;
                        res.drib   = pend_next.drib;
                        res.delay  = reply_delay(pend_next.slot);
                    end
                    else
                    begin
                        res.status = ST_NOMATCH;
                    end
                end
                res.kick   = kick_next;
                res.flags  = flags_next;
                res.accel  = accel_next;
                index_next = '0;
                slot_next  = '0;
                off_next   = '0;
                found_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= '0;
            index_reg  <= '0;
            slot_reg   <= '0;
            off_reg    <= '0;
            found_reg  <= 1'b0;
            pend_reg   <= '0;
            kick_reg   <= '0;
            flags_reg  <= '0;
            accel_reg  <= '0;
        end
        else
        begin
            if (own_id_wr_en)
            begin
                own_id_reg <= own_id_wr_data;
            end
            index_reg <= index_next;
            slot_reg  <= slot_next;
            off_reg   <= off_next;
            found_reg <= found_next;
            pend_reg  <= pend_next;
            kick_reg  <= kick_next;
            flags_reg <= flags_next;
            accel_reg <= accel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sb_we)
        begin
            sb_reg[off_reg[1:0]] <= rx_byte;
        end
    end

endmodule

// ===== hdl/scp_outbuf.sv =====
// Output register with a skid stage for parsed packet results.
`timescale 1ns / 1ps

module scp_outbuf
    import scp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic space,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_next       = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== dv/tb_slotted_command_packet_parser.sv =====
// Self-checking testbench for the slotted command packet parser: random and directed packets.
`timescale 1ns / 1ps

module tb_slotted_command_packet_parser;
    import scp_pkg::*;

    localparam int LONG_HOLD = 400;
    localparam int GAP_PCT   = 28;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        own_id_wr_en = 1'b0;
    logic [3:0]  own_id_wr_data = 4'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    rx_item_t   rx_bytes[$];
    logic [7:0] pkt_buf[$];
    res_t       due_results[$];

    logic [3:0] model_id = 4'd0;
    logic [5:0] rx_pos = 6'd0;
    logic [7:0] slot_hold[4];
    logic       hit = 1'b0;
    pend_t      cmd_pend = '0;
    logic [7:0] keep_kick = 8'd0;
    logic [3:0] keep_flags = 4'd0;
    logic [5:0] keep_accel = 6'd0;

    logic send_gaps = 1'b1;
    logic recv_gaps = 1'b1;
    int   stall_asks = 0;
    int   stall_done = 0;
    int   stall_left = 0;
    int   fail_count = 0;

    slotted_command_packet_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .own_id_wr_en   (own_id_wr_en),
        .own_id_wr_data (own_id_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

    always #1 clk = ~clk;

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        int unsigned pos;
        int unsigned slot;
        int unsigned off;
        res_t r;
        pos = rx_pos;
        if (pos < PACKET_BYTES)
        begin
            if (pos == 0)
            begin
                cmd_pend = '0;
                hit = 1'b0;
                cmd_pend.seq = b[2:0];
            end
            else
            begin
                slot = (pos - 1) / SLOT_BYTES;
                off = (pos - 1) % SLOT_BYTES;
                if (slot < SLOT_COUNT)
                begin
                    if (off < OFF_ID)
                    begin
                        if (!hit)
                        begin
                            slot_hold[off] = b;
                        end
                    end
                    else if (off == OFF_ID)
                    begin
                        if (!hit && b[3:0] == model_id)
                        begin
                            hit = 1'b1;
                            cmd_pend.slot = slot[SLOT_W-1:0];
                            cmd_pend.vel_x = {slot_hold[OFF_HIGH][1:0], slot_hold[0]};
                            cmd_pend.vel_y = {slot_hold[OFF_HIGH][3:2], slot_hold[1]};
                            cmd_pend.vel_w = {slot_hold[OFF_HIGH][5:4], slot_hold[2]};
                            // The 4-bit speed is replicated to fill nine bits.
                            cmd_pend.drib = {b[7:4], b[7:4], b[7]};
                        end
                    end
                    else if (hit && cmd_pend.slot == slot)
                    begin
                        if (off == OFF_KICK)
                        begin
                            cmd_pend.kick = b;
                        end
                        else if (off == OFF_FLAGS)
                        begin
                            cmd_pend.flags = b[3:0];
                        end
                        else if (off == OFF_ACCEL)
                        begin
                            cmd_pend.accel = (b > ACCEL_MAX) ? 6'(ACCEL_MAX) : b[5:0];
                        end
                    end
                end
            end
        end
        if (rx_pos != INDEX_MAX)
        begin
            rx_pos = rx_pos + 6'd1;
        end
        if (last)
        begin
            r = '0;
            if (pos != PACKET_BYTES - 1)
            begin
                r.status = ST_BADLEN;
            end
            else
            begin
                r.seq = cmd_pend.seq;
                if (hit)
                begin
                    keep_kick = cmd_pend.kick;
                    keep_flags = cmd_pend.flags;
                    keep_accel = cmd_pend.accel;
                    r.status = ST_MATCH;
                    r.slot = cmd_pend.slot;
                    r.vel_x = cmd_pend.vel_x;
                    r.vel_y = cmd_pend.vel_y;
                    r.vel_w = cmd_pend.vel_w;
                    r.drib = cmd_pend.drib;
                    r.delay = DELAY_W'(DELAY_PER_SLOT * int'(cmd_pend.slot));
                    if (r.delay < DELAY_MIN)
                    begin
                        r.delay = DELAY_W'(DELAY_MIN);
                    end
                end
                else
                begin
                    r.status = ST_NOMATCH;
                end
            end
            r.kick = keep_kick;
            r.flags = keep_flags;
            r.accel = keep_accel;
            due_results.push_back(r);
            rx_pos = 6'd0;
            hit = 1'b0;
        end
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_byte(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready)
            begin
                if (rx_bytes.size() != 0 && !(send_gaps && $urandom_range(0, 99) < GAP_PCT))
                begin
                    s_tdata <= rx_bytes[0].data;
                    s_tlast <= rx_bytes[0].last;
                    s_tvalid <= 1'b1;
                    void'(rx_bytes.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d data %h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    compare_field("packet_status", due_results[0].status, m_tuser);
                    compare_field("seq_number", due_results[0].seq, m_tdata[2:0]);
                    compare_field("matched_slot", due_results[0].slot, m_tdata[5:3]);
                    compare_field("vel_x", due_results[0].vel_x, m_tdata[15:6]);
                    compare_field("vel_y", due_results[0].vel_y, m_tdata[25:16]);
                    compare_field("vel_w", due_results[0].vel_w, m_tdata[35:26]);
                    compare_field("dribbler_speed", due_results[0].drib, m_tdata[44:36]);
                    compare_field("kick_strength", due_results[0].kick, m_tdata[52:45]);
                    compare_field("kick_flags", due_results[0].flags, m_tdata[56:53]);
                    compare_field("accel_cap", due_results[0].accel, m_tdata[62:57]);
                    compare_field("reply_delay", due_results[0].delay, m_tdata[76:63]);
                    void'(due_results.pop_front());
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (stall_asks != stall_done)
            begin
                stall_done++;
                stall_left = LONG_HOLD;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !(recv_gaps && $urandom_range(0, 99) < GAP_PCT);
            end
        end
    end

    function automatic logic [3:0] other_id();
        return model_id ^ 4'($urandom_range(1, 15));
    endfunction

    task automatic put_slot(input logic [3:0] id, input logic [9:0] x, input logic [9:0] y,
                            input logic [9:0] w, input logic [3:0] drib,
                            input logic [7:0] kick, input logic [7:0] flags,
                            input logic [7:0] accel);
        logic [7:0] junk;
        logic [7:0] spare;
        junk = 8'($urandom());
        spare = 8'($urandom());
        pkt_buf.push_back(x[7:0]);
        pkt_buf.push_back(y[7:0]);
        pkt_buf.push_back(w[7:0]);
        pkt_buf.push_back({junk[7:6], w[9:8], y[9:8], x[9:8]});
        pkt_buf.push_back({drib, id});
        pkt_buf.push_back(kick);
        pkt_buf.push_back(flags);
        pkt_buf.push_back(accel);
        pkt_buf.push_back(spare);
    endtask

    task automatic put_rand_slot(input logic [3:0] id);
        logic [7:0] accel;
        if ($urandom_range(0, 1) == 0)
        begin
            accel = 8'($urandom());
        end
        else
        begin
            accel = 8'($urandom_range(30, 50));
        end
        put_slot(id, 10'($urandom()), 10'($urandom()), 10'($urandom()), 4'($urandom()),
                 8'($urandom()), 8'($urandom()), accel);
    endtask

    // A target of SLOT_COUNT puts no matching id in any slot.
    task automatic build_packet(input int target);
        pkt_buf.push_back(8'($urandom()));
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (i == target)
            begin
                put_rand_slot(model_id);
            end
            else if (i < target)
            begin
                put_rand_slot(other_id());
            end
            else
            begin
                put_rand_slot(4'($urandom()));
            end
        end
    endtask

    task automatic send_packet(input int len);
        while (pkt_buf.size() < len)
        begin
            pkt_buf.push_back(8'($urandom()));
        end
        while (pkt_buf.size() > len)
        begin
            void'(pkt_buf.pop_back());
        end
        foreach (pkt_buf[i])
        begin
            rx_bytes.push_back('{pkt_buf[i], i == len - 1});
        end
        pkt_buf.delete();
    endtask

    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (rx_bytes.size() != 0 || s_tvalid || due_results.size() != 0);
    endtask

    task automatic write_own_id(input logic [3:0] id);
        repeat (3) @(posedge clk);
        own_id_wr_en <= 1'b1;
        own_id_wr_data <= id;
        @(posedge clk);
        own_id_wr_en <= 1'b0;
        model_id = id;
        @(negedge clk);
    endtask

    initial
    begin
        #500000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int phase;
        int rand_bytes;
        int rand_pkts;
        int len;
        int kind;
        phase = 0;
        rand_bytes = 0;
        rand_pkts = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_own_id(4'd0);

        pkt_buf.push_back(8'hff);
        put_slot(4'd0, 10'h200, 10'h1ff, 10'h3ff, 4'hf, 8'hff, 8'hff, 8'hff);
        for (int i = 1; i < SLOT_COUNT; i++)
        begin
            put_rand_slot(other_id());
        end
        send_packet(PACKET_BYTES);

        pkt_buf.push_back(8'h00);
        for (int i = 0; i < SLOT_COUNT - 1; i++)
        begin
            put_rand_slot(other_id());
        end
        put_slot(4'd0, 10'h000, 10'h000, 10'h000, 4'h0, 8'h00, 8'h00, 8'd40);
        send_packet(PACKET_BYTES);

        build_packet(SLOT_COUNT);
        send_packet(PACKET_BYTES);
        build_packet(0);
        send_packet(1);
        build_packet(SLOT_COUNT - 1);
        send_packet(PACKET_BYTES - 1);

        pkt_buf.push_back(8'($urandom()));
        put_rand_slot(other_id());
        put_slot(4'd0, 10'($urandom()), 10'($urandom()), 10'($urandom()), 4'h5,
                 8'h5a, 8'h0a, 8'd41);
        put_rand_slot(other_id());
        put_rand_slot(4'd0);
        put_rand_slot(other_id());
        put_rand_slot(other_id());
        send_packet(PACKET_BYTES);

        build_packet(2);
        send_packet(PACKET_BYTES + 1);
        build_packet(1);
        send_packet(70);
        drain();

        write_own_id(4'd15);
        pkt_buf.push_back(8'h07);
        put_rand_slot(other_id());
        put_rand_slot(other_id());
        put_slot(4'd15, 10'h155, 10'h2aa, 10'h0f0, 4'ha, 8'h80, 8'h05, 8'd39);
        put_rand_slot(other_id());
        put_rand_slot(4'd15);
        put_rand_slot(4'($urandom()));
        send_packet(PACKET_BYTES);
        drain();

        while (rand_bytes < 1200 || rand_pkts < 24)
        begin
            if (phase % 4 == 0)
            begin
                write_own_id(4'd0);
            end
            else if (phase % 4 == 1)
            begin
                write_own_id(4'd15);
            end
            else
            begin
                write_own_id(4'($urandom()));
            end
            send_gaps = (phase != 1 && phase != 2);
            recv_gaps = (phase != 1);
            if (phase == 2)
            begin
                stall_asks++;
            end
            for (int n = 0; n < 6; n++)
            begin
                kind = $urandom_range(0, 99);
                build_packet($urandom_range(0, SLOT_COUNT));
                if (kind < 70)
                begin
                    len = PACKET_BYTES;
                end
                else if (kind < 85)
                begin
                    len = $urandom_range(1, PACKET_BYTES - 1);
                end
                else
                begin
                    len = $urandom_range(PACKET_BYTES + 1, 80);
                end
                send_packet(len);
                rand_bytes += len;
                rand_pkts++;
            end
            drain();
            phase++;
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
